### rtl/core/btlq_pkg.sv
// btlq_pkg: shared types, constants and queue cursor helpers for the
// button tap / long-press qualifier. No dependencies.
`default_nettype none

package btlq_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int CUR_MOD     = 2 * QUEUE_DEPTH;
  localparam int CUR_W       = $clog2(CUR_MOD);
  localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int LONG_W      = 20;
  localparam int TAP_MIN_W   = 16;
  localparam int TIME_W      = 32;
  localparam int QCOUNT_W    = 3;

  localparam logic [LONG_W-1:0]    LONG_HOLD_RESET = 20'd3000;
  localparam logic [TAP_MIN_W-1:0] TAP_MIN_RESET   = 16'd30;

  typedef logic [CUR_W-1:0]  cursor_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    FUNC_SAMPLE   = 2'd0,
    FUNC_POP_TAP  = 2'd1,
    FUNC_POP_LONG = 2'd2
  } func_t;

  typedef enum logic [0:0] {
    REG_LONG_HOLD = 1'b0,
    REG_TAP_MIN   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                tap_found;
    logic [TIME_W-1:0]   tap_time_ms;
    logic                long_press_seen;
    logic [QCOUNT_W-1:0] taps_queued;
  } rsp_t;

  function automatic cursor_t cur_inc(input cursor_t c);
    cursor_t r;
    r = (c == cursor_t'(CUR_MOD - 1)) ? '0 : c + cursor_t'(1);
    return r;
  endfunction

  function automatic slot_t cur_slot(input cursor_t c);
    slot_t s;
    if (c >= cursor_t'(QUEUE_DEPTH)) begin
      s = slot_t'(c - cursor_t'(QUEUE_DEPTH));
    end else begin
      s = slot_t'(c);
    end
    return s;
  endfunction

  function automatic cursor_t cur_fill(input cursor_t w, input cursor_t r);
    logic [CUR_W:0] d;
    if (w >= r) begin
      d = {1'b0, w} - {1'b0, r};
    end else begin
      d = {1'b0, w} + (CUR_W + 1)'(CUR_MOD) - {1'b0, r};
    end
    return cursor_t'(d);
  endfunction

endpackage

`default_nettype wire

### rtl/core/btlq_cmd_if.sv
// btlq_cmd_if: command item channel (valid/ready) of the qualifier.
// Depends on btlq_pkg for field widths.
`default_nettype none

interface btlq_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic                          pressed_level;
  logic [btlq_pkg::TIME_W-1:0]   time_ms;

  modport source (output valid, output func, output pressed_level, output time_ms,
                  input ready);
  modport sink   (input valid, input func, input pressed_level, input time_ms,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/btlq_rsp_if.sv
// btlq_rsp_if: result item channel (valid/ready) of the qualifier.
// Depends on btlq_pkg for field widths.
`default_nettype none

interface btlq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          tap_found;
  logic [btlq_pkg::TIME_W-1:0]   tap_time_ms;
  logic                          long_press_seen;
  logic [btlq_pkg::QCOUNT_W-1:0] taps_queued;

  modport source (output valid, output tap_found, output tap_time_ms,
                  output long_press_seen, output taps_queued, input ready);
  modport sink   (input valid, input tap_found, input tap_time_ms,
                  input long_press_seen, input taps_queued, output ready);
endinterface

`default_nettype wire

### rtl/core/button_tap_longpress_qualifier_unit.sv
// button_tap_longpress_qualifier_unit: top level of the button qualifier.
// Depends on btlq_pkg, btlq_cmd_if and btlq_rsp_if.
//
// usage:
//   cmd carries one item per handshake: func selects a button sample, a tap
//   pop or a long-press pop; pressed_level and time_ms go with a sample.
//   rsp returns exactly one result item per command item, in order.
//   the apb port sets long_hold_ms (addr 0) and tap_min_ms (addr 4); write
//   only while no items are in flight.
// timing:
//   a result is registered after its command is accepted. one item per
//   cycle is sustained while rsp keeps taking results: state update and result
//   are a single compare/update pass between the command handshake and the output registers.
// stall:
//   a two-entry output (result register plus skid register) lets one more
//   item in while a result waits; cmd.ready drops only when the skid holds
//   an item, and rises again the cycle after rsp takes one.
// reset:
//   rst clears the button state, the long flag, both queue cursors and the
//   output valids, and restores the register defaults. the tap store itself
//   is not cleared; only written entries are ever read.
`default_nettype none

module button_tap_longpress_qualifier_unit (
  input  wire                            clk,
  input  wire                            rst,
  btlq_cmd_if.sink                       cmd,
  btlq_rsp_if.source                     rsp,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [btlq_pkg::ADDR_W-1:0]     paddr,
  input  wire [btlq_pkg::DATA_W-1:0]     pwdata,
  output logic [btlq_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  logic [btlq_pkg::LONG_W-1:0]    long_hold_ms;
  logic [btlq_pkg::TAP_MIN_W-1:0] tap_min_ms;

  logic                           held_down, held_down_next;
  logic [btlq_pkg::TIME_W-1:0]    press_start_ms, press_start_ms_next;
  logic                           long_marked, long_marked_next;
  logic                           long_flag, long_flag_next;
  btlq_pkg::cursor_t              wr_cursor, wr_cursor_next;
  btlq_pkg::cursor_t              rd_cursor, rd_cursor_next;
  logic [btlq_pkg::TIME_W-1:0]    tap_times [btlq_pkg::QUEUE_DEPTH];

  logic                           push_en;
  logic [btlq_pkg::TIME_W-1:0]    start_eff;
  logic [btlq_pkg::TIME_W-1:0]    elapsed;
  logic [btlq_pkg::TIME_W-1:0]    long_ext;
  logic [btlq_pkg::TIME_W-1:0]    tap_min_ext;
  btlq_pkg::cursor_t              fill_now;
  btlq_pkg::cursor_t              fill_after;
  logic [31:0]                    fill_wide;
  btlq_pkg::rsp_t                 rsp_next;

  btlq_pkg::rsp_t                 out_q;
  logic                           out_valid;
  btlq_pkg::rsp_t                 skid_q;
  logic                           skid_valid;

  logic                           accept;
  logic                           pop;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_hold_ms <= btlq_pkg::LONG_HOLD_RESET;
      tap_min_ms   <= btlq_pkg::TAP_MIN_RESET;
    end else if (cfg_wr) begin
      case (btlq_pkg::reg_idx_t'(paddr[2]))
        btlq_pkg::REG_LONG_HOLD: long_hold_ms <= pwdata[btlq_pkg::LONG_W-1:0];
        btlq_pkg::REG_TAP_MIN:   tap_min_ms   <= pwdata[btlq_pkg::TAP_MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (btlq_pkg::reg_idx_t'(paddr[2]))
      btlq_pkg::REG_LONG_HOLD: prdata = btlq_pkg::DATA_W'(long_hold_ms);
      btlq_pkg::REG_TAP_MIN:   prdata = btlq_pkg::DATA_W'(tap_min_ms);
      default:                 prdata = '0;
    endcase
  end

  assign cmd.ready = !skid_valid;
  assign accept    = cmd.valid && cmd.ready;
  assign pop       = out_valid && rsp.ready;

  assign long_ext    = btlq_pkg::TIME_W'(long_hold_ms);
  assign tap_min_ext = btlq_pkg::TIME_W'(tap_min_ms);
  assign fill_now    = btlq_pkg::cur_fill(wr_cursor, rd_cursor);
  assign start_eff   = held_down ? press_start_ms : cmd.time_ms;
  assign elapsed     = cmd.time_ms - start_eff;

  always_comb begin
    held_down_next      = held_down;
    press_start_ms_next = press_start_ms;
    long_marked_next    = long_marked;
    long_flag_next      = long_flag;
    wr_cursor_next      = wr_cursor;
    rd_cursor_next      = rd_cursor;
    push_en             = 1'b0;
    rsp_next            = '0;

    case (cmd.func)
      btlq_pkg::FUNC_SAMPLE: begin
        if (cmd.pressed_level) begin
          held_down_next      = 1'b1;
          press_start_ms_next = start_eff;
          long_marked_next    = held_down ? long_marked : 1'b0;
          if (!long_marked_next && elapsed >= long_ext) begin
            long_marked_next = 1'b1;
            long_flag_next   = 1'b1;
          end
        end else if (held_down) begin
          held_down_next = 1'b0;
          if (!long_marked) begin
            if (elapsed >= long_ext) begin
              long_marked_next = 1'b1;
              long_flag_next   = 1'b1;
            end else if (elapsed >= tap_min_ext &&
                         fill_now < btlq_pkg::cursor_t'(btlq_pkg::QUEUE_DEPTH)) begin
              push_en        = 1'b1;
              wr_cursor_next = btlq_pkg::cur_inc(wr_cursor);
            end
          end
        end
      end
      btlq_pkg::FUNC_POP_TAP: begin
        if (fill_now != '0) begin
          rsp_next.tap_found   = 1'b1;
          rsp_next.tap_time_ms = tap_times[btlq_pkg::cur_slot(rd_cursor)];
          rd_cursor_next       = btlq_pkg::cur_inc(rd_cursor);
        end
      end
      btlq_pkg::FUNC_POP_LONG: begin
        rsp_next.long_press_seen = long_flag;
        long_flag_next           = 1'b0;
      end
      default: ;
    endcase

    fill_after           = btlq_pkg::cur_fill(wr_cursor_next, rd_cursor_next);
    fill_wide            = 32'(fill_after);
    rsp_next.taps_queued = fill_wide[btlq_pkg::QCOUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_down      <= 1'b0;
      press_start_ms <= '0;
      long_marked    <= 1'b0;
      long_flag      <= 1'b0;
      wr_cursor      <= '0;
      rd_cursor      <= '0;
    end else if (accept) begin
      held_down      <= held_down_next;
      press_start_ms <= press_start_ms_next;
      long_marked    <= long_marked_next;
      long_flag      <= long_flag_next;
      wr_cursor      <= wr_cursor_next;
      rd_cursor      <= rd_cursor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push_en) begin
      tap_times[btlq_pkg::cur_slot(wr_cursor)] <= cmd.time_ms;
    end
  end

  // result register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_q <= rsp_next;
      end else begin
        out_q <= rsp_next;
      end
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.tap_found       = out_q.tap_found;
  assign rsp.tap_time_ms     = out_q.tap_time_ms;
  assign rsp.long_press_seen = out_q.long_press_seen;
  assign rsp.taps_queued     = out_q.taps_queued;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while the result register is empty");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_now <= btlq_pkg::cursor_t'(btlq_pkg::QUEUE_DEPTH))
    else $error("tap queue fill beyond its depth");

  a_pop_long_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.func == btlq_pkg::FUNC_POP_LONG) |=> !long_flag)
    else $error("long flag still pending after a pop-long item");

  a_release_on_item: assert property (@(posedge clk) disable iff (rst)
    $fell(held_down) |-> $past(accept))
    else $error("button state changed without an accepted item");

endmodule

`default_nettype wire
